FILE: rtl/sers_pkg.sv
// package: payload types, codes and defaults for the sorted equal-range search block
package sers_pkg;

	localparam int DEPTH_DEF       = 1024;
	localparam int VALUE_WIDTH_DEF = 32;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_ENTRY_COUNT = 1'b0;   // register index, paddr[2]

	localparam int COUNT_W = 11;
	localparam int INDEX_W = 10;
	localparam int KEY_W   = 32;

	// item operations
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	typedef struct packed {
		logic                      opcode;
		logic [INDEX_W-1:0]        entry_index;
		logic signed [KEY_W-1:0]   operand_value;
	} in_item_t;

	typedef struct packed {
		logic                      found;
		logic [INDEX_W-1:0]        first_index;
		logic [INDEX_W-1:0]        last_index;
		logic [COUNT_W-1:0]        match_count;
	} out_item_t;

endpackage

FILE: rtl/sorted_equal_range_search.sv
// Sorted equal-range search: a table of signed values in one synchronous memory, searched
// by two binary searches (leftmost match, then rightmost match). A write beat stores one
// entry and is taken with no result. A search beat walks the memory one probe at a time
// (address out, then registered read data back and compared), since each midpoint
// depends on the previous compare through the single read port; when both passes are
// done, its result beat is offered. The result sits in an output register, so the next
// beat is accepted while it waits. Entries must be written before a search can probe them.
module sorted_equal_range_search #(
	parameter int DEPTH       = sers_pkg::DEPTH_DEF,
	parameter int VALUE_WIDTH = sers_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sers_pkg::PADDR_W-1:0]  paddr,
	input  logic [sers_pkg::PDATA_W-1:0]  pwdata,
	output logic [sers_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	// item channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  sers_pkg::in_item_t            in_data,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output sers_pkg::out_item_t           out_data
);

	localparam int AW = $clog2(DEPTH);
	localparam int IW = AW + 2;                               // signed search bounds
	localparam int CW = (AW + 1 > sers_pkg::COUNT_W) ? AW + 1 : sers_pkg::COUNT_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHK,
		ST_CMP,
		ST_FIN
	} state_t;

	state_t                        state_q;
	logic [sers_pkg::COUNT_W-1:0]  count_q;
	logic signed [VALUE_WIDTH-1:0] key_q;
	logic signed [IW-1:0]          left_q;
	logic signed [IW-1:0]          right_q;
	logic [AW-1:0]                 mid_q;
	logic [AW-1:0]                 hit_q;
	logic                          hit_found_q;
	logic [AW-1:0]                 first_q;
	logic                          first_found_q;
	logic                          pass_q;
	logic                          out_valid_q;
	sers_pkg::out_item_t           out_data_q;

	logic signed [VALUE_WIDTH-1:0] mem [DEPTH];
	logic signed [VALUE_WIDTH-1:0] rdata_q;

	logic                          in_beat;
	logic                          cfg_wr;
	logic [31:0]                   wr_idx_w;
	logic                          wr_en;
	logic [AW-1:0]                 wr_addr;
	logic signed [VALUE_WIDTH-1:0] in_key;
	logic [AW:0]                   n_w;
	logic signed [IW-1:0]          right_init;
	logic signed [IW-1:0]          mid_sum;
	logic [AW-1:0]                 mid;
	logic                          probe;
	logic signed [IW-1:0]          mid_ext;
	logic [AW-1:0]                 last_sel;
	logic [CW-1:0]                 count_diff;

	// handshakes
	assign in_ready = (state_q == ST_IDLE);
	assign in_beat  = in_valid && in_ready;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// register read back
	assign prdata = (paddr[2] == sers_pkg::REG_ENTRY_COUNT) ?
		sers_pkg::PDATA_W'(count_q) : '0;

	// entry count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_wr && paddr[2] == sers_pkg::REG_ENTRY_COUNT) begin
			count_q <= pwdata[sers_pkg::COUNT_W-1:0];
		end
	end

	// key wrapped to the table width
	assign in_key = VALUE_WIDTH'($signed(in_data.operand_value));

	// write decode, out-of-range index dropped
	assign wr_idx_w = 32'(in_data.entry_index);
	assign wr_en    = in_beat && (in_data.opcode == sers_pkg::OP_WRITE) &&
		(wr_idx_w < 32'(DEPTH));
	assign wr_addr  = wr_idx_w[AW-1:0];

	// search span, count saturated at depth
	assign n_w        = (32'(count_q) > 32'(DEPTH)) ? (AW+1)'(DEPTH) : (AW+1)'(count_q);
	assign right_init = $signed(IW'(n_w)) - IW'(1);

	// probe midpoint
	assign mid_sum = left_q + right_q;
	assign mid     = mid_sum[AW:1];
	assign probe   = (state_q == ST_CHK) && (left_q <= right_q);
	assign mid_ext = $signed(IW'(mid_q));

	// result assembly
	assign last_sel   = hit_found_q ? hit_q : first_q;
	assign count_diff = CW'(last_sel) - CW'(first_q) + CW'(1);

	// table write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= in_key;
		end
	end

	// table read port, registered data
	always_ff @(posedge clk) begin
		if (probe) begin
			rdata_q <= mem[mid];
		end
	end

	// search sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			pass_q      <= 1'b0;
			hit_found_q <= 1'b0;
			first_found_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat && in_data.opcode == sers_pkg::OP_SEARCH) begin
						key_q       <= in_key;
						left_q      <= '0;
						right_q     <= right_init;
						hit_found_q <= 1'b0;
						pass_q      <= 1'b0;
						state_q     <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (probe) begin
						mid_q   <= mid;
						state_q <= ST_CMP;
					end else if (!pass_q) begin
						// leftmost pass done, start the rightmost pass
						first_found_q <= hit_found_q;
						first_q       <= hit_q;
						hit_found_q   <= 1'b0;
						left_q        <= '0;
						right_q       <= right_init;
						pass_q        <= 1'b1;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_CMP: begin
					priority if (rdata_q == key_q) begin
						hit_q       <= mid_q;
						hit_found_q <= 1'b1;
						if (!pass_q) begin
							right_q <= mid_ext - IW'(1);
						end else begin
							left_q <= mid_ext + IW'(1);
						end
					end else if (rdata_q < key_q) begin
						left_q <= mid_ext + IW'(1);
					end else begin
						right_q <= mid_ext - IW'(1);
					end
					state_q <= ST_CHK;
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						if (first_found_q) begin
							out_data_q.found       <= 1'b1;
							out_data_q.first_index <= sers_pkg::INDEX_W'(first_q);
							out_data_q.last_index  <= sers_pkg::INDEX_W'(last_sel);
							out_data_q.match_count <= count_diff[sers_pkg::COUNT_W-1:0];
						end else begin
							out_data_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/sers_checker.sv
// checker: port-level assertions for the sorted equal-range search block, with its bind
module sers_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input sers_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input sers_pkg::out_item_t out_data
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat dropped or changed while stalled");

	// a miss reports all zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.found |->
			out_data.first_index == '0 && out_data.last_index == '0 &&
			out_data.match_count == '0)
		else $error("miss result carries nonzero fields");

	// a hit count follows its bounds
	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.found |->
			out_data.match_count == sers_pkg::COUNT_W'(
				sers_pkg::COUNT_W'(out_data.last_index) -
				sers_pkg::COUNT_W'(out_data.first_index) + sers_pkg::COUNT_W'(1)))
		else $error("match count disagrees with first and last index");

	// a write beat never raises a result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.opcode == sers_pkg::OP_WRITE |=> !$rose(out_valid))
		else $error("result beat raised by a write");

endmodule

bind sorted_equal_range_search sers_checker u_sers_checker (.*);
